>>> design/iosd_pkg.sv
// ----------------------------------------------------------------------------
// iosd_pkg: shared types and constants for the I/O expander shadow block
// Word width, opcodes, the request and result records, and the pin mask helper.
// ----------------------------------------------------------------------------
package iosd_pkg;

  localparam int WORD_BITS     = 40;
  localparam int PIN_COUNT_DEF = 40;
  localparam int IDX_BITS      = 6;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_SET_PIN = 1'b1
  } op_t;

  typedef struct packed {
    op_t                 op;
    word_t               raw_pins;
    logic [IDX_BITS-1:0] pin_index;
    logic                pin_level;
  } item_t;

  typedef struct packed {
    word_t drive_word;
    word_t shadow_word;
    word_t settled_word;
    word_t fell_low;
  } result_t;

  // Bits of pins that exist: below both the pin count and the word width.
  function automatic word_t pin_mask(input int pin_count);
    word_t m;
    m = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      m[i] = (i < pin_count);
    end
    return m;
  endfunction

endpackage

>>> design/io_expander_shadow_debounce.sv
// ----------------------------------------------------------------------------
// io_expander_shadow_debounce: pin shadow and debounce for an I/O expander
// Keeps the pin shadow, a direction register and a per-pin debounce counter.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the in_ channel (valid/ready). A sample request masks
// in_raw_pins with the direction bits, steps the debounce counters and
// refreshes the input bits of the shadow. A set-pin request writes one
// output bit of the shadow. Each request gives exactly one result on the
// out_ channel: drive word, shadow, debounced state and newly-low pins.
// The direction register is written through cfg_wr_en/cfg_wr_data; the user
// must do so only while the block is idle, which the block does not enforce.
// An accepted request is loaded into the input register, and its state
// update is then written into the result register, raising out_valid.
// Throughput is one request per cycle while the receiver does not stall,
// set by the single state update.
// Reset clears the direction register, shadow, debounce state and both
// valid flags. When the receiver stalls the result register holds, the
// input register fills next, and in_ready drops once both are occupied.
// ----------------------------------------------------------------------------
module io_expander_shadow_debounce #(
  parameter int PIN_COUNT = iosd_pkg::PIN_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  iosd_pkg::word_t               cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  iosd_pkg::word_t               in_raw_pins,
  input  logic [iosd_pkg::IDX_BITS-1:0] in_pin_index,
  input  logic                          in_pin_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output iosd_pkg::word_t               out_drive_word,
  output iosd_pkg::word_t               out_shadow_word,
  output iosd_pkg::word_t               out_settled_word,
  output iosd_pkg::word_t               out_fell_low
);
  import iosd_pkg::*;

  item_t   in_item, item;
  result_t res, out_res;
  logic    item_valid, res_ready, fire;

  assign in_item.op        = op_t'(in_op);
  assign in_item.raw_pins  = in_raw_pins;
  assign in_item.pin_index = in_pin_index;
  assign in_item.pin_level = in_pin_level;

  assign fire = item_valid && res_ready;

  iosd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (fire),
    .item       (item)
  );

  iosd_core #(
    .PIN_COUNT (PIN_COUNT)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .item        (item),
    .result      (res)
  );

  iosd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (item_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_drive_word   = out_res.drive_word;
  assign out_shadow_word  = out_res.shadow_word;
  assign out_settled_word = out_res.settled_word;
  assign out_fell_low     = out_res.fell_low;

endmodule

>>> design/iosd_in_reg.sv
// ----------------------------------------------------------------------------
// iosd_in_reg: input request register
// Captures one request per cycle while the core keeps taking them, and holds each until the core takes it.
// ----------------------------------------------------------------------------
module iosd_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  iosd_pkg::item_t in_item,
  output logic           item_valid,
  input  logic           item_take,
  output iosd_pkg::item_t item
);
  import iosd_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready = !valid_r || item_take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> design/iosd_core.sv
// ----------------------------------------------------------------------------
// iosd_core: pin shadow, direction register and vertical-counter debounce
// Updates the shadow and debounce state for one request and forms its result in the same cycle.
// ----------------------------------------------------------------------------
module iosd_core #(
  parameter int PIN_COUNT = iosd_pkg::PIN_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  iosd_pkg::word_t  cfg_wr_data,
  input  logic             fire,
  input  iosd_pkg::item_t  item,
  output iosd_pkg::result_t result
);
  import iosd_pkg::*;

  localparam word_t PinMask = pin_mask(PIN_COUNT);

  word_t dir_r;
  word_t shadow_r, shadow_nxt;
  word_t deb_r, deb_nxt;
  word_t hi_r, hi_nxt;
  word_t lo_r, lo_nxt;

  word_t dir, masked, diff, flips, fell, bit_sel;

  always_comb begin
    dir        = dir_r & PinMask;
    masked     = item.raw_pins & dir;
    diff       = (masked ^ deb_r) & PinMask;
    shadow_nxt = shadow_r;
    deb_nxt    = deb_r;
    hi_nxt     = hi_r;
    lo_nxt     = lo_r;
    flips      = '0;
    fell       = '0;
    // The shift leaves zero for an index at or past the word width.
    bit_sel    = (word_t'(1) << item.pin_index) & PinMask;
    case (item.op)
      OP_SAMPLE: begin
        // Two-bit counter per pin; agreeing pins clear, a wrap flips the pin.
        hi_nxt     = (hi_r ^ lo_r) & diff;
        lo_nxt     = ~lo_r & diff;
        flips      = diff & ~hi_nxt & ~lo_nxt;
        deb_nxt    = (deb_r ^ flips) & PinMask;
        fell       = flips & ~deb_nxt;
        shadow_nxt = ((shadow_r & ~dir) | masked) & PinMask;
      end
      OP_SET_PIN: begin
        if ((bit_sel & ~dir) != '0) begin
          shadow_nxt = item.pin_level ? (shadow_r | bit_sel) : (shadow_r & ~bit_sel);
        end
      end
      default: begin
        shadow_nxt = shadow_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r    <= '0;
      shadow_r <= '0;
      deb_r    <= '0;
      hi_r     <= '0;
      lo_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        dir_r <= cfg_wr_data;
      end
      if (fire) begin
        shadow_r <= shadow_nxt;
        deb_r    <= deb_nxt;
        hi_r     <= hi_nxt;
        lo_r     <= lo_nxt;
      end
    end
  end

  assign result.drive_word   = shadow_nxt & ~dir;
  assign result.shadow_word  = shadow_nxt;
  assign result.settled_word = deb_nxt;
  assign result.fell_low     = fell;

endmodule

>>> design/iosd_out_reg.sv
// ----------------------------------------------------------------------------
// iosd_out_reg: result register
// Holds one finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module iosd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  output logic              res_ready,
  input  iosd_pkg::result_t res,
  output logic              out_valid,
  input  logic              out_ready,
  output iosd_pkg::result_t out_res
);
  import iosd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign res_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_ready) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

>>> design/iosd_checker.sv
// ----------------------------------------------------------------------------
// iosd_checker: port-level checks for io_expander_shadow_debounce
// Watches the result channel for consistency between fields and over stalls.
// ----------------------------------------------------------------------------
module iosd_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input iosd_pkg::word_t out_drive_word,
  input iosd_pkg::word_t out_shadow_word,
  input iosd_pkg::word_t out_settled_word,
  input iosd_pkg::word_t out_fell_low
);
  import iosd_pkg::*;

  // A reset cycle leaves no result pending.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // The drive word is the shadow with input pins cleared, so never wider.
  a_drive_in_shadow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_drive_word & ~out_shadow_word) == '0))
    else $error("drive word has a bit the shadow lacks");

  // A pin that just fell low must read low in the debounced state.
  a_fell_is_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_fell_low & out_settled_word) == '0))
    else $error("fell_low marks a pin that is settled high");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_shadow_word)
      && $stable(out_settled_word) && $stable(out_fell_low))
    else $error("result changed while stalled");

endmodule

bind io_expander_shadow_debounce iosd_checker u_iosd_checker (.*);

>>> verif/tb_io_expander_shadow_debounce.sv
// ----------------------------------------------------------------------------
// tb_io_expander_shadow_debounce: self-checking bench for the pin shadow block
// Drives sample and set-pin requests under random idling and a long result
// stall. A behavioral copy of the shadow and the debounce counters predicts
// every result, and each result is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_io_expander_shadow_debounce;
  import iosd_pkg::*;

  localparam int RANDOM_PER_PHASE = 150;
  localparam int HOLD_CYCLES      = 64;
  localparam int DRAIN_CYCLES     = 8;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int MAX_REPORTS      = 10;

  localparam word_t ALL_ONES = {WORD_BITS{1'b1}};

  typedef struct {
    bit      is_cfg;
    word_t   cfg_value;
    item_t   req;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                cfg_wr_en    = 1'b0;
  word_t               cfg_wr_data  = '0;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic                in_op        = OP_SAMPLE;
  word_t               in_raw_pins  = '0;
  logic [IDX_BITS-1:0] in_pin_index = '0;
  logic                in_pin_level = 1'b0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  word_t               out_drive_word;
  word_t               out_shadow_word;
  word_t               out_settled_word;
  word_t               out_fell_low;

  // Behavioral copy of the block state.
  word_t dir_mirror    = '0;
  word_t shadow_model  = '0;
  word_t settled_model = '0;
  word_t cnt_hi_model  = '0;
  word_t cnt_lo_model  = '0;

  result_t  pending_status[$];
  dir_row_t dir_table[$];

  int          send_idle_pct = 12;
  int          recv_idle_pct = 45;
  bit          hold_req      = 1'b0;
  bit          hold_ack      = 1'b0;
  int          hold_left     = 0;
  int          mismatches    = 0;
  int unsigned tick_count    = 0;

  io_expander_shadow_debounce u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_raw_pins      (in_raw_pins),
    .in_pin_index     (in_pin_index),
    .in_pin_level     (in_pin_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_drive_word   (out_drive_word),
    .out_shadow_word  (out_shadow_word),
    .out_settled_word (out_settled_word),
    .out_fell_low     (out_fell_low)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Advances the shadow and the two-bit vertical counters by one request.
  function automatic result_t compute_pin_status(input item_t req);
    word_t   dir;
    word_t   masked;
    word_t   diff;
    word_t   flips;
    word_t   fell;
    result_t r;
    dir  = dir_mirror;
    fell = '0;
    if (req.op == OP_SAMPLE) begin
      masked        = req.raw_pins & dir;
      diff          = masked ^ settled_model;
      cnt_hi_model  = (cnt_hi_model ^ cnt_lo_model) & diff;
      cnt_lo_model  = ~cnt_lo_model & diff;
      // A pin flips when its counter wraps back to zero while it still differs.
      flips         = diff & ~cnt_hi_model & ~cnt_lo_model;
      settled_model = settled_model ^ flips;
      fell          = flips & ~settled_model;
      shadow_model  = (shadow_model & ~dir) | masked;
    end else if (req.pin_index < PIN_COUNT_DEF && !dir[req.pin_index]) begin
      shadow_model[req.pin_index] = req.pin_level;
    end
    r.drive_word   = shadow_model & ~dir;
    r.shadow_word  = shadow_model;
    r.settled_word = settled_model;
    r.fell_low     = fell;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input word_t value);
    dir_row_t row;
    row           = '{default: '0};
    row.is_cfg    = 1'b1;
    row.cfg_value = value;
    return row;
  endfunction

  function automatic dir_row_t req_row(input op_t op, input word_t raw,
                                       input int idx, input bit lvl);
    dir_row_t row;
    row               = '{default: '0};
    row.req.op        = op;
    row.req.raw_pins  = raw;
    row.req.pin_index = IDX_BITS'(idx);
    row.req.pin_level = lvl;
    return row;
  endfunction

  // Rows before any direction write: nothing settles, so only the shadow moves.
  function automatic dir_row_t typed_row(input op_t op, input word_t raw, input int idx,
                                         input bit lvl, input word_t drive,
                                         input word_t shadow);
    dir_row_t row;
    row                    = req_row(op, raw, idx, lvl);
    row.typed              = 1'b1;
    row.want.drive_word    = drive;
    row.want.shadow_word   = shadow;
    row.want.settled_word  = '0;
    row.want.fell_low      = '0;
    return row;
  endfunction

  task automatic wait_results_drained();
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_dir(input word_t value);
    in_valid <= 1'b0;
    wait_results_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    dir_mirror = value;
  endtask

  task automatic offer_request(input item_t req, input bit typed, input result_t want);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= req.op;
    in_raw_pins  <= req.raw_pins;
    in_pin_index <= req.pin_index;
    in_pin_level <= req.pin_level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = compute_pin_status(req);
    pending_status.push_back(typed ? want : predicted);
  endtask

  task automatic run_phase(input word_t dir, input int send_pct, input int recv_pct,
                           input bit hold);
    item_t   req;
    word_t   held_raw;
    result_t unused;
    write_dir(dir);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    if (hold) hold_req <= ~hold_req;
    held_raw = '0;
    unused   = '0;
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      req.op        = OP_SAMPLE;
      req.raw_pins  = word_t'({$urandom, $urandom});
      req.pin_index = IDX_BITS'($urandom_range(63));
      req.pin_level = 1'($urandom_range(1));
      if ($urandom_range(99) < 25) begin
        req.op = OP_SET_PIN;
        if ($urandom_range(9) != 0) req.pin_index = IDX_BITS'($urandom_range(39));
      end else begin
        // Held patterns let the counters wrap; an occasional change restarts them.
        case ($urandom_range(9))
          0: held_raw = word_t'({$urandom, $urandom});
          1: held_raw = held_raw ^ (word_t'(1) << $urandom_range(WORD_BITS - 1));
          default: ;
        endcase
        req.raw_pins = held_raw;
      end
      offer_request(req, 1'b0, unused);
    end
    in_valid <= 1'b0;
  endtask

  // Receiver side: random stalls, plus one long hold-off when requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: drive %h shadow %h settled %h fell %h",
                   out_drive_word, out_shadow_word, out_settled_word, out_fell_low);
      end else begin
        if (out_drive_word   !== pending_status[0].drive_word   ||
            out_shadow_word  !== pending_status[0].shadow_word  ||
            out_settled_word !== pending_status[0].settled_word ||
            out_fell_low     !== pending_status[0].fell_low) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: exp drive %h shadow %h settled %h fell %h / got %h %h %h %h",
                     pending_status[0].drive_word, pending_status[0].shadow_word,
                     pending_status[0].settled_word, pending_status[0].fell_low,
                     out_drive_word, out_shadow_word, out_settled_word, out_fell_low);
        end
        void'(pending_status.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    tick_count <= tick_count + 1;
    if (tick_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    // Direction is still all outputs here, so results can be read off directly.
    dir_table.push_back(typed_row(OP_SAMPLE, ALL_ONES, 0, 1'b0, '0, '0));
    dir_table.push_back(typed_row(OP_SET_PIN, '0, 0, 1'b1, 40'h1, 40'h1));
    dir_table.push_back(typed_row(OP_SET_PIN, '0, 39, 1'b1, 40'h80_0000_0001,
                                  40'h80_0000_0001));
    dir_table.push_back(typed_row(OP_SET_PIN, ALL_ONES, 40, 1'b1, 40'h80_0000_0001,
                                  40'h80_0000_0001));
    dir_table.push_back(typed_row(OP_SET_PIN, '0, 63, 1'b0, 40'h80_0000_0001,
                                  40'h80_0000_0001));
    dir_table.push_back(typed_row(OP_SET_PIN, '0, 39, 1'b0, 40'h1, 40'h1));
    dir_table.push_back(typed_row(OP_SAMPLE, '0, 0, 1'b0, 40'h1, 40'h1));
    // All inputs: four high samples settle every pin, then a set-pin on an input.
    dir_table.push_back(cfg_row(ALL_ONES));
    repeat (4) dir_table.push_back(req_row(OP_SAMPLE, ALL_ONES, 0, 1'b0));
    dir_table.push_back(req_row(OP_SET_PIN, '0, 5, 1'b0));
    // Three low samples, a bounce back high, then four lows so every pin falls.
    repeat (3) dir_table.push_back(req_row(OP_SAMPLE, '0, 0, 1'b0));
    dir_table.push_back(req_row(OP_SAMPLE, ALL_ONES, 0, 1'b0));
    repeat (4) dir_table.push_back(req_row(OP_SAMPLE, '0, 63, 1'b1));
    // Mixed directions: output pins are forced low in the debounce path.
    dir_table.push_back(cfg_row(40'hF0_0F0F_F0C3));
    dir_table.push_back(req_row(OP_SET_PIN, '0, 2, 1'b1));
    dir_table.push_back(req_row(OP_SET_PIN, '0, 0, 1'b1));
    repeat (4) dir_table.push_back(req_row(OP_SAMPLE, ALL_ONES, 0, 1'b0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      if (dir_table[i].is_cfg) begin
        write_dir(dir_table[i].cfg_value);
      end else begin
        offer_request(dir_table[i].req, dir_table[i].typed, dir_table[i].want);
      end
    end
    in_valid <= 1'b0;

    run_phase(word_t'({$urandom, $urandom}), 12, 45, 1'b0);
    run_phase('0, 45, 12, 1'b0);
    run_phase(word_t'({$urandom, $urandom}), 0, 0, 1'b1);

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
design/iosd_pkg.sv
design/iosd_in_reg.sv
design/iosd_core.sv
design/iosd_out_reg.sv
design/io_expander_shadow_debounce.sv
design/iosd_checker.sv
verif/tb_io_expander_shadow_debounce.sv
